// ===== rtl/adsr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the ADSR sine tone generator.
// No dependencies; every other file but adsr_div imports this package.
package adsr_pkg;

   localparam int OSC_BITS      = 32;
   localparam int GAIN_BITS     = 25;
   localparam int LEVEL_BITS    = 17;
   localparam int LEN_REG_BITS  = 24;
   localparam int PHASE_BITS    = 3;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // Envelope phase codes
   localparam logic [PHASE_BITS-1:0] PH_ATTACK  = 3'd0;
   localparam logic [PHASE_BITS-1:0] PH_DECAY   = 3'd1;
   localparam logic [PHASE_BITS-1:0] PH_SUSTAIN = 3'd2;
   localparam logic [PHASE_BITS-1:0] PH_RELEASE = 3'd3;
   localparam logic [PHASE_BITS-1:0] PH_SILENT  = 3'd4;

   // Register indexes
   localparam logic [CSR_ADDR_BITS-1:0] CSR_OSC_COEFF     = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_OSC_START     = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ATTACK_LEN    = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_DECAY_LEN     = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SUSTAIN_LEN   = 3'd4;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_RELEASE_LEN   = 3'd5;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SUSTAIN_LEVEL = 3'd6;

   // Unity gain in Q1.24 and full-scale sustain level in Q1.16
   localparam logic [GAIN_BITS-1:0]  GAIN_ONE  = 25'h100_0000;
   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 17'h1_0000;

   typedef struct packed {
      logic mul_restart;  // product <= coeff * start
      logic mul_tick;     // product <= coeff * prev1
      logic mul_sample;   // product <= prev1 * gain
      logic osc_reload;   // reload oscillator, clear envelope
      logic osc_advance;  // shift oscillator taps
      logic env_advance;  // take sample, ramp gain, count down
      logic env_enter;    // enter next non-empty phase
      logic step_load;    // take ramp step from divider
      logic out_load;     // load output register
   } adsr_cmd_type;

   typedef struct packed {
      logic silent;
      logic rem_last;
      logic need_div;
      logic div_busy;
   } adsr_sts_type;

endpackage

// ===== rtl/adsr_div.sv =====
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by adsr_dp for ramp steps.
module adsr_div #(
   parameter int NUM_BITS = 25,
   parameter int DEN_BITS = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] num,
   input  logic [DEN_BITS-1:0] den,
   output logic                busy,
   output logic [NUM_BITS-1:0] quot
);

   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   logic                busy_ff;
   logic [CNT_BITS-1:0] count_ff;
   logic [DEN_BITS-1:0] rem_ff, rem_in;
   logic [DEN_BITS-1:0] den_ff;
   logic [NUM_BITS-1:0] quot_ff, quot_in;
   logic [DEN_BITS:0]   shifted, diff;
   logic                ge;

   always_comb begin
      shifted = {rem_ff, quot_ff[NUM_BITS-1]};
      diff    = shifted - {1'b0, den_ff};
      ge      = (shifted >= {1'b0, den_ff});
      rem_in  = ge ? diff[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];
      quot_in = {quot_ff[NUM_BITS-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else if (start) begin
         busy_ff  <= 1'b1;
         count_ff <= CNT_BITS'(NUM_BITS);
      end else if (busy_ff) begin
         count_ff <= count_ff - 1'b1;
         if (count_ff == CNT_BITS'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= '0;
         den_ff  <= den;
         quot_ff <= num;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
      end
   end

   assign busy = busy_ff;
   assign quot = quot_ff;

endmodule

// ===== rtl/adsr_dp.sv =====
`timescale 1ns / 1ps
// Datapath: config registers, oscillator taps, shared multiplier, envelope state,
// output register. Depends on adsr_pkg and adsr_div.
module adsr_dp #(
   parameter int LEN_BITS    = 24,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [adsr_pkg::CSR_ADDR_BITS-1:0]    csr_addr,
   input  logic [adsr_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  adsr_pkg::adsr_cmd_type                cmd,
   output adsr_pkg::adsr_sts_type                sts,
   output logic signed [SAMPLE_BITS-1:0]         rsp_sample,
   output logic [adsr_pkg::PHASE_BITS-1:0]       rsp_phase,
   output logic                                  rsp_done_res,
   output logic                                  rsp_envelope_error
);

   import adsr_pkg::*;

   localparam int LW = (LEN_BITS < LEN_REG_BITS) ? LEN_BITS : LEN_REG_BITS;
   localparam int SMP_SHIFT = 55 - SAMPLE_BITS;
   localparam logic signed [63:0] Q30_HALF = 64'sd536870912;
   localparam logic signed [63:0] SMP_HALF = 64'sd1 <<< (SMP_SHIFT - 1);
   localparam logic signed [63:0] SMP_MAX  = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
   localparam logic signed [63:0] SMP_MIN  = -SMP_MAX - 64'sd1;

   function automatic logic signed [OSC_BITS-1:0] sat_osc(input logic signed [34:0] v);
      if (v > 35'sd2147483647) begin
         return 32'sh7fff_ffff;
      end else if (v < -35'sd2147483648) begin
         return 32'sh8000_0000;
      end else begin
         return $signed(v[31:0]);
      end
   endfunction

   // Configuration
   logic signed [OSC_BITS-1:0] coeff_ff, start_ff;
   logic [LEN_REG_BITS-1:0]    att_len_ff, dec_len_ff, sus_len_ff, rel_len_ff;
   logic [LEVEL_BITS-1:0]      level_ff;

   // State
   logic signed [OSC_BITS-1:0] prev1_ff, prev2_ff;
   logic [PHASE_BITS-1:0]      phase_ff, entry_pt_ff;
   logic [LW-1:0]              rem_ff;
   logic [GAIN_BITS-1:0]       gain_ff, step_ff;
   logic                       error_ff;
   logic signed [63:0]         prod_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff;

   logic [LW-1:0] att_len, dec_len, sus_len, rel_len;
   logic [GAIN_BITS-1:0] level_gain;
   logic signed [OSC_BITS-1:0] mul_a, mul_b;
   logic signed [63:0] prod_q30_rnd, smp_rnd, smp_clamp;
   logic signed [33:0] osc_prod;
   logic signed [34:0] osc_prod_ext, osc_diff;
   logic [GAIN_BITS:0] gain_sum;
   logic [GAIN_BITS-1:0] gain_next;
   logic [LW-1:0] rem_next;

   logic [PHASE_BITS-1:0] ent_phase;
   logic                  ent_err, ent_need_div;
   logic [LW-1:0]         ent_len;
   logic [GAIN_BITS-1:0]  ent_gain, div_num, div_quot;
   logic                  div_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff   <= '0;
         start_ff   <= '0;
         att_len_ff <= '0;
         dec_len_ff <= '0;
         sus_len_ff <= LEN_REG_BITS'(1);
         rel_len_ff <= '0;
         level_ff   <= LEVEL_MAX;
      end else if (csr_wr_en) begin
         case (csr_addr)
            CSR_OSC_COEFF:     coeff_ff   <= $signed(csr_wdata[OSC_BITS-1:0]);
            CSR_OSC_START:     start_ff   <= $signed(csr_wdata[OSC_BITS-1:0]);
            CSR_ATTACK_LEN:    att_len_ff <= csr_wdata[LEN_REG_BITS-1:0];
            CSR_DECAY_LEN:     dec_len_ff <= csr_wdata[LEN_REG_BITS-1:0];
            CSR_SUSTAIN_LEN:   sus_len_ff <= csr_wdata[LEN_REG_BITS-1:0];
            CSR_RELEASE_LEN:   rel_len_ff <= csr_wdata[LEN_REG_BITS-1:0];
            CSR_SUSTAIN_LEVEL: level_ff   <= csr_wdata[LEVEL_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign att_len = att_len_ff[LW-1:0];
   assign dec_len = dec_len_ff[LW-1:0];
   assign sus_len = sus_len_ff[LW-1:0];
   assign rel_len = rel_len_ff[LW-1:0];
   assign level_gain = (level_ff > LEVEL_MAX) ? {LEVEL_MAX, 8'h00} : {level_ff, 8'h00};

   // Shared multiplier, product registered
   always_comb begin
      mul_a = coeff_ff;
      mul_b = start_ff;
      if (cmd.mul_tick) begin
         mul_b = prev1_ff;
      end
      if (cmd.mul_sample) begin
         mul_a = prev1_ff;
         mul_b = $signed(32'(gain_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_restart || cmd.mul_tick || cmd.mul_sample) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   // Round products: Q2.30 for the oscillator, Q1.(SAMPLE_BITS-1) for the sample
   always_comb begin
      prod_q30_rnd = prod_ff + Q30_HALF;
      osc_prod     = $signed(prod_q30_rnd[63:30]);
      osc_prod_ext = {osc_prod[33], osc_prod};
      osc_diff     = osc_prod_ext - {{3{prev2_ff[OSC_BITS-1]}}, prev2_ff};
      smp_rnd      = (prod_ff + SMP_HALF) >>> SMP_SHIFT;
      if (smp_rnd > SMP_MAX) begin
         smp_clamp = SMP_MAX;
      end else if (smp_rnd < SMP_MIN) begin
         smp_clamp = SMP_MIN;
      end else begin
         smp_clamp = smp_rnd;
      end
   end

   // Gain ramp and countdown
   always_comb begin
      gain_sum = {1'b0, gain_ff} + {1'b0, step_ff};
      case (phase_ff)
         PH_ATTACK: begin
            gain_next = (gain_sum > {1'b0, GAIN_ONE}) ? GAIN_ONE
                                                      : gain_sum[GAIN_BITS-1:0];
         end
         PH_DECAY, PH_RELEASE: begin
            gain_next = (gain_ff > step_ff) ? gain_ff - step_ff : '0;
         end
         default: gain_next = gain_ff;
      endcase
      rem_next = (rem_ff != '0) ? rem_ff - 1'b1 : rem_ff;
   end

   // Resolve the first non-empty phase from the entry point
   always_comb begin
      ent_phase = PH_SILENT;
      ent_err   = 1'b0;
      case (entry_pt_ff)
         PH_ATTACK: begin
            if (att_len != '0) ent_phase = PH_ATTACK;
            else if (dec_len != '0) ent_phase = PH_DECAY;
            else if (sus_len != '0) ent_phase = PH_SUSTAIN;
            else ent_err = 1'b1;
         end
         PH_DECAY: begin
            if (dec_len != '0) ent_phase = PH_DECAY;
            else if (sus_len != '0) ent_phase = PH_SUSTAIN;
            else ent_err = 1'b1;
         end
         PH_SUSTAIN: begin
            if (sus_len != '0) ent_phase = PH_SUSTAIN;
            else ent_err = 1'b1;
         end
         PH_RELEASE: begin
            if (rel_len != '0) ent_phase = PH_RELEASE;
         end
         default: ;
      endcase

      ent_len      = '0;
      ent_gain     = gain_ff;
      div_num      = GAIN_ONE;
      ent_need_div = 1'b0;
      case (ent_phase)
         PH_ATTACK: begin
            ent_len      = att_len;
            ent_gain     = '0;
            ent_need_div = 1'b1;
         end
         PH_DECAY: begin
            ent_len      = dec_len;
            ent_gain     = GAIN_ONE;
            div_num      = GAIN_ONE - level_gain;
            ent_need_div = 1'b1;
         end
         PH_SUSTAIN: begin
            ent_len  = sus_len;
            ent_gain = level_gain;
         end
         PH_RELEASE: begin
            ent_len      = rel_len;
            ent_gain     = level_gain;
            div_num      = level_gain;
            ent_need_div = 1'b1;
         end
         default: ;
      endcase
   end

   adsr_div #(
      .NUM_BITS (GAIN_BITS),
      .DEN_BITS (LW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.env_enter & ent_need_div),
      .num   (div_num),
      .den   (ent_len),
      .busy  (div_busy),
      .quot  (div_quot)
   );

   // Oscillator and envelope state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev1_ff    <= '0;
         prev2_ff    <= '0;
         phase_ff    <= PH_SUSTAIN;
         entry_pt_ff <= PH_ATTACK;
         rem_ff      <= LW'(1);
         gain_ff     <= GAIN_ONE;
         step_ff     <= '0;
         error_ff    <= 1'b0;
      end else begin
         if (cmd.osc_reload) begin
            prev1_ff    <= start_ff;
            prev2_ff    <= sat_osc(osc_prod_ext);
            error_ff    <= 1'b0;
            gain_ff     <= '0;
            step_ff     <= '0;
            entry_pt_ff <= PH_ATTACK;
         end
         if (cmd.osc_advance) begin
            prev2_ff <= prev1_ff;
            prev1_ff <= sat_osc(osc_diff);
         end
         if (cmd.env_advance) begin
            gain_ff     <= gain_next;
            rem_ff      <= rem_next;
            entry_pt_ff <= phase_ff + 3'd1;
         end
         if (cmd.env_enter) begin
            phase_ff <= ent_phase;
            rem_ff   <= ent_len;
            gain_ff  <= ent_gain;
            step_ff  <= '0;
            if (ent_err) begin
               error_ff <= 1'b1;
            end
         end
         if (cmd.step_load) begin
            step_ff <= div_quot;
         end
      end
   end

   // Sample and output register
   always_ff @(posedge clock) begin
      if (cmd.osc_advance) begin
         sample_ff <= '0;
      end
      if (cmd.env_advance) begin
         sample_ff <= smp_clamp[SAMPLE_BITS-1:0];
      end
      if (cmd.out_load) begin
         rsp_sample         <= sample_ff;
         rsp_phase          <= phase_ff;
         rsp_done_res       <= (phase_ff == PH_SILENT);
         rsp_envelope_error <= error_ff;
      end
   end

   assign sts.silent   = (phase_ff == PH_SILENT);
   assign sts.rem_last = (rem_ff <= LW'(1));
   assign sts.need_div = ent_need_div;
   assign sts.div_busy = div_busy;

   a_gain_bounded: assert property (@(posedge clock) disable iff (reset)
      gain_ff <= GAIN_ONE)
      else $error("envelope gain above unity");

   a_silent_no_step: assert property (@(posedge clock) disable iff (reset)
      (step_ff != '0) |-> (phase_ff != PH_SILENT))
      else $error("ramp step left set in silent phase");

endmodule

// ===== rtl/adsr_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences restart, oscillator step, envelope step, phase entry
// and output hand-off. Depends on adsr_pkg.
module adsr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_restart,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  adsr_pkg::adsr_sts_type sts,
   output adsr_pkg::adsr_cmd_type cmd
);

   import adsr_pkg::*;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_R_MUL  = 4'd1;
   localparam logic [3:0] ST_R_LOAD = 4'd2;
   localparam logic [3:0] ST_ENTER  = 4'd3;
   localparam logic [3:0] ST_DIV    = 4'd4;
   localparam logic [3:0] ST_T_MUL  = 4'd5;
   localparam logic [3:0] ST_T_OSC  = 4'd6;
   localparam logic [3:0] ST_T_SMUL = 4'd7;
   localparam logic [3:0] ST_T_ENV  = 4'd8;
   localparam logic [3:0] ST_OUT    = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [3:0] ret_state;
   logic       in_tick_ff, in_tick_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign ret_state = in_tick_ff ? ST_OUT : ST_T_MUL;

   always_comb begin
      state_in   = state_ff;
      in_tick_in = in_tick_ff;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               in_tick_in = 1'b0;
               state_in   = req_restart ? ST_R_MUL : ST_T_MUL;
            end
         end
         ST_R_MUL: begin
            cmd.mul_restart = 1'b1;
            state_in        = ST_R_LOAD;
         end
         ST_R_LOAD: begin
            cmd.osc_reload = 1'b1;
            state_in       = ST_ENTER;
         end
         ST_ENTER: begin
            cmd.env_enter = 1'b1;
            state_in      = sts.need_div ? ST_DIV : ret_state;
         end
         ST_DIV: begin
            if (!sts.div_busy) begin
               cmd.step_load = 1'b1;
               state_in      = ret_state;
            end
         end
         ST_T_MUL: begin
            cmd.mul_tick = 1'b1;
            in_tick_in   = 1'b1;
            state_in     = ST_T_OSC;
         end
         ST_T_OSC: begin
            cmd.osc_advance = 1'b1;
            state_in        = sts.silent ? ST_OUT : ST_T_SMUL;
         end
         ST_T_SMUL: begin
            cmd.mul_sample = 1'b1;
            state_in       = ST_T_ENV;
         end
         ST_T_ENV: begin
            cmd.env_advance = 1'b1;
            state_in        = sts.rem_last ? ST_ENTER : ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_tick_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_tick_ff   <= in_tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("output register loaded while result still held");

   a_div_started: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && $past(state_ff) == ST_ENTER) |-> sts.div_busy)
      else $error("divider not running after phase entry");

   a_valid_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_OUT))
      else $error("result raised outside output state");

endmodule

// ===== rtl/adsr_sine_tone_generator.sv =====
`timescale 1ns / 1ps
// Top level of the ADSR-enveloped sine tone generator.
// Depends on adsr_pkg, adsr_ctrl, adsr_dp (and adsr_div below it).
//
//   channel | ports                               | direction
//   --------+-------------------------------------+----------
//   req     | req_valid req_stall req_restart     | in  (one item per sample tick)
//   rsp     | rsp_valid rsp_stall rsp_sample      | out (one item per tick)
//           | rsp_phase rsp_done_res              |
//           | rsp_envelope_error                  |
//   csr     | csr_wr_en csr_addr csr_wdata        | in  (write only)
//
// An ordinary tick runs the oscillator multiply, the oscillator update, the gain
// multiply, the envelope step and the output hand-off: one shared 32x32
// multiplier is used twice, once for the oscillator recursion and once for the
// envelope gain. A tick in the silent phase skips the gain multiply.
// Entering a ramp phase waits for the 25-step restoring divider that finds the
// ramp step; entering a flat or silent phase does not. A restart first reloads
// the oscillator and always enters a phase.
// Synchronous active-high reset leaves the block ready, with the envelope in
// sustain at unity gain. The next item is accepted while a result waits in the
// output register; a held result stalls only the hand-off of the following one.
module adsr_sine_tone_generator #(
   parameter int LEN_BITS    = 24,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_restart,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]      rsp_sample,
   output logic [adsr_pkg::PHASE_BITS-1:0]    rsp_phase,
   output logic                               rsp_done_res,
   output logic                               rsp_envelope_error,
   input  logic                               csr_wr_en,
   input  logic [adsr_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [adsr_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   import adsr_pkg::*;

   adsr_cmd_type cmd;
   adsr_sts_type sts;

   // Sequencer: owns the handshakes and steps the datapath
   adsr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_restart (req_restart),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .sts         (sts),
      .cmd         (cmd)
   );

   // Arithmetic, state, config registers and output register
   adsr_dp #(
      .LEN_BITS    (LEN_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_addr           (csr_addr),
      .csr_wdata          (csr_wdata),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_sample         (rsp_sample),
      .rsp_phase          (rsp_phase),
      .rsp_done_res       (rsp_done_res),
      .rsp_envelope_error (rsp_envelope_error)
   );

endmodule

// ===== tb/adsr_tone_checker.sv =====
`timescale 1ns / 1ps
// Checker for the ADSR sine tone generator: mirrors the register writes, predicts
// every tick item in its own model and compares each rsp item field by field.
// Depends on adsr_pkg only.
module adsr_tone_checker #(
   parameter int LEN_BITS    = 24,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic                               req_restart,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic signed [SAMPLE_BITS-1:0]      rsp_sample,
   input  logic [adsr_pkg::PHASE_BITS-1:0]    rsp_phase,
   input  logic                               rsp_done_res,
   input  logic                               rsp_envelope_error,
   input  logic                               csr_wr_en,
   input  logic [adsr_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [adsr_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output int                                 fail_count,
   output int                                 outstanding
);
   import adsr_pkg::*;

   localparam longint UNITY        = longint'(GAIN_ONE);
   localparam int     SAMPLE_SHIFT = 55 - SAMPLE_BITS;
   localparam longint SAMPLE_MAX   = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint LEN_MASK     = (64'sd1 <<< LEN_BITS) - 1;

   typedef struct {
      logic [SAMPLE_BITS-1:0] sample;
      logic [PHASE_BITS-1:0]  phase;
      logic                   done;
      logic                   err;
   } tone_result_type;

   // register copies
   logic signed [31:0]       coeff_reg, start_reg;
   logic [LEN_REG_BITS-1:0]  attack_reg, decay_reg, sustain_reg, release_reg;
   logic [LEVEL_BITS-1:0]    level_reg;

   // oscillator and envelope state
   logic signed [31:0]       osc_y1, osc_y2;
   logic [PHASE_BITS-1:0]    env_phase;
   longint                   env_left, env_gain, env_step;
   logic                     env_err;

   tone_result_type          expected_tones[$];
   tone_result_type          next_tone, want;
   int                       failures = 0;

   // Q2.30 product, rounded to nearest with ties upwards
   function automatic longint q30_product(logic signed [31:0] a, logic signed [31:0] b);
      longint p;
      p = longint'(a) * longint'(b);
      return (p + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647)
         return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648)
         return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // sustain level in Q1.24, out-of-range levels held at unity
   function automatic longint sustain_gain();
      longint l;
      l = (level_reg > LEVEL_MAX) ? longint'(LEVEL_MAX) : longint'(level_reg);
      return l <<< 8;
   endfunction

   function automatic void enter_release();
      longint n;
      n = longint'(release_reg) & LEN_MASK;
      if (n > 0) begin
         env_phase = PH_RELEASE;
         env_left  = n;
         env_gain  = sustain_gain();
         env_step  = env_gain / n;
      end else begin
         env_phase = PH_SILENT;
         env_left  = 0;
         env_step  = 0;
      end
   endfunction

   function automatic void enter_sustain();
      longint n;
      n = longint'(sustain_reg) & LEN_MASK;
      if (n > 0) begin
         env_phase = PH_SUSTAIN;
         env_left  = n;
         env_gain  = sustain_gain();
         env_step  = 0;
      end else begin
         env_phase = PH_SILENT;
         env_left  = 0;
         env_step  = 0;
         env_err   = 1'b1;
      end
   endfunction

   function automatic void enter_decay();
      longint n;
      n = longint'(decay_reg) & LEN_MASK;
      if (n > 0) begin
         env_phase = PH_DECAY;
         env_left  = n;
         env_gain  = UNITY;
         env_step  = (UNITY - sustain_gain()) / n;
      end else begin
         enter_sustain();
      end
   endfunction

   function automatic void enter_attack();
      longint n;
      n = longint'(attack_reg) & LEN_MASK;
      if (n > 0) begin
         env_phase = PH_ATTACK;
         env_left  = n;
         env_gain  = 0;
         env_step  = UNITY / n;
      end else begin
         enter_decay();
      end
   endfunction

   function automatic void restart_tone();
      osc_y1   = start_reg;
      osc_y2   = clamp32(q30_product(coeff_reg, start_reg));
      env_err  = 1'b0;
      env_gain = 0;
      env_step = 0;
      enter_attack();
   endfunction

   function automatic tone_result_type predict_tone_tick(logic restart);
      tone_result_type    res;
      logic signed [31:0] y0;
      longint             p, s;
      if (restart)
         restart_tone();
      y0     = clamp32(q30_product(coeff_reg, osc_y1) - longint'(osc_y2));
      osc_y2 = osc_y1;
      osc_y1 = y0;
      s      = 0;
      if (env_phase != PH_SILENT) begin
         p = longint'(y0) * env_gain;
         s = (p + (64'sd1 <<< (SAMPLE_SHIFT - 1))) >>> SAMPLE_SHIFT;
         if (s > SAMPLE_MAX)
            s = SAMPLE_MAX;
         if (s < -SAMPLE_MAX - 1)
            s = -SAMPLE_MAX - 1;
         if (env_phase == PH_ATTACK) begin
            env_gain = env_gain + env_step;
            if (env_gain > UNITY)
               env_gain = UNITY;
         end else if (env_phase == PH_DECAY || env_phase == PH_RELEASE) begin
            env_gain = (env_gain > env_step) ? env_gain - env_step : 0;
         end
         if (env_left > 0)
            env_left = env_left - 1;
         if (env_left == 0) begin
            case (env_phase)
               PH_ATTACK:  enter_decay();
               PH_DECAY:   enter_sustain();
               PH_SUSTAIN: enter_release();
               default: begin
                  env_phase = PH_SILENT;
                  env_step  = 0;
               end
            endcase
         end
      end
      res.sample = s[SAMPLE_BITS-1:0];
      res.phase  = env_phase;
      res.done   = (env_phase == PH_SILENT);
      res.err    = env_err;
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         coeff_reg   = '0;
         start_reg   = '0;
         attack_reg  = '0;
         decay_reg   = '0;
         sustain_reg = 24'd1;
         release_reg = '0;
         level_reg   = LEVEL_MAX;
         restart_tone();
         expected_tones.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_addr)
               CSR_OSC_COEFF:     coeff_reg   = csr_wdata;
               CSR_OSC_START:     start_reg   = csr_wdata;
               CSR_ATTACK_LEN:    attack_reg  = csr_wdata[LEN_REG_BITS-1:0];
               CSR_DECAY_LEN:     decay_reg   = csr_wdata[LEN_REG_BITS-1:0];
               CSR_SUSTAIN_LEN:   sustain_reg = csr_wdata[LEN_REG_BITS-1:0];
               CSR_RELEASE_LEN:   release_reg = csr_wdata[LEN_REG_BITS-1:0];
               CSR_SUSTAIN_LEVEL: level_reg   = csr_wdata[LEVEL_BITS-1:0];
               default: ;
            endcase
         end
         // compare before queueing, so a stray result never meets this edge's tick
         if (rsp_valid && !rsp_stall) begin
            if (expected_tones.size() == 0) begin
               $error("rsp item with no tick waiting for it");
               failures++;
            end else begin
               want = expected_tones.pop_front();
               if (rsp_sample !== want.sample) begin
                  $error("rsp_sample: expected %0d, got %0d",
                         $signed(want.sample), rsp_sample);
                  failures++;
               end
               if (rsp_phase !== want.phase) begin
                  $error("rsp_phase: expected %0d, got %0d", want.phase, rsp_phase);
                  failures++;
               end
               if (rsp_done_res !== want.done) begin
                  $error("rsp_done_res: expected %0b, got %0b", want.done, rsp_done_res);
                  failures++;
               end
               if (rsp_envelope_error !== want.err) begin
                  $error("rsp_envelope_error: expected %0b, got %0b",
                         want.err, rsp_envelope_error);
                  failures++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            next_tone = predict_tone_tick(req_restart);
            expected_tones.push_back(next_tone);
         end
      end
      outstanding <= expected_tones.size();
      fail_count  <= failures;
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the ADSR sine tone generator: clock, reset, register set-up,
// tick stimulus and the verdict. Depends on adsr_pkg, the RTL and adsr_tone_checker.
module tb;
   import adsr_pkg::*;

   localparam int ITEM_TARGET = 1350;
   // The limit leaves a wide margin over the slowest tick, solid rsp stalls and
   // sender gaps for some 1400 items.
   localparam int CYCLE_LIMIT = 800000;
   localparam int TAIL_CYCLES = 100;

   // 2*cos(pi/8) in Q2.30 and -sin(pi/8) in Q2.30
   localparam logic [31:0] PI8_COEFF = 32'd1984016189;
   localparam logic [31:0] PI8_START = -32'sd410903207;
   localparam logic [23:0] LEN_MAX   = 24'hFF_FFFF;

   // receiver stall patterns
   localparam int STALL_NONE   = 0;
   localparam int STALL_RANDOM = 1;
   localparam int STALL_SOLID  = 2;
   localparam int STALL_TOGGLE = 3;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_restart = 1'b0;
   logic                     rsp_stall   = 1'b0;
   logic                     csr_wr_en   = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr    = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata   = '0;

   wire                      req_stall;
   wire                      rsp_valid;
   wire signed [15:0]        rsp_sample;
   wire [PHASE_BITS-1:0]     rsp_phase;
   wire                      rsp_done_res;
   wire                      rsp_envelope_error;

   int fail_count, outstanding;
   int items_sent  = 0;
   int burst_left  = 0;
   int cycle_count = 0;
   int stall_run   = 0;
   int stall_kind  = STALL_NONE;
   int seg_len;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   adsr_sine_tone_generator #(
      .LEN_BITS    (24),
      .SAMPLE_BITS (16)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_restart        (req_restart),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sample         (rsp_sample),
      .rsp_phase          (rsp_phase),
      .rsp_done_res       (rsp_done_res),
      .rsp_envelope_error (rsp_envelope_error),
      .csr_wr_en          (csr_wr_en),
      .csr_addr           (csr_addr),
      .csr_wdata          (csr_wdata)
   );

   adsr_tone_checker #(
      .LEN_BITS    (24),
      .SAMPLE_BITS (16)
   ) u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_restart        (req_restart),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sample         (rsp_sample),
      .rsp_phase          (rsp_phase),
      .rsp_done_res       (rsp_done_res),
      .rsp_envelope_error (rsp_envelope_error),
      .csr_wr_en          (csr_wr_en),
      .csr_addr           (csr_addr),
      .csr_wdata          (csr_wdata),
      .fail_count         (fail_count),
      .outstanding        (outstanding)
   );

   // Receiver: run one stall pattern for a random stretch, then pick another.
   // Solid stalls are kept short so the sender never waits for long.
   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_kind = $urandom_range(STALL_NONE, STALL_TOGGLE);
         stall_run  = (stall_kind == STALL_SOLID) ? $urandom_range(1, 12)
                                                  : $urandom_range(8, 80);
      end else begin
         stall_run--;
      end
      case (stall_kind)
         STALL_NONE:   rsp_stall <= 1'b0;
         STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
         STALL_SOLID:  rsp_stall <= 1'b1;
         default:      rsp_stall <= ~rsp_stall;
      endcase
   end

   // Watchdog: give up if the run hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Offer one tick item and hold it until taken. Items go out in bursts;
   // between bursts drop valid for a random gap, and now and then skip the gap.
   task automatic send_tick(input logic restart);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
         burst_left = $urandom_range(1, 30);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      items_sent++;
   endtask

   // A run of ticks: the first may restart the tone, later ones restart
   // with odds of one in restart_odds (never when zero).
   task automatic tick_series(input logic first_restart, input int count,
                              input int restart_odds);
      send_tick(first_restart);
      for (int i = 1; i < count; i++)
         send_tick(restart_odds != 0 && $urandom_range(1, restart_odds) == 1);
   endtask

   // Stop sending and wait until every tick has come back, so the block is idle
   task automatic drain();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_BITS-1:0] idx, input logic [31:0] value);
      csr_wr_en <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Write the registers picked by mask (bit i for register index i)
   task automatic load_envelope(input logic [6:0] mask, input logic [31:0] coeff,
                                input logic [31:0] start, input logic [23:0] attack,
                                input logic [23:0] decay, input logic [23:0] sustain,
                                input logic [23:0] rel, input logic [16:0] level);
      if (mask[CSR_OSC_COEFF])     write_reg(CSR_OSC_COEFF, coeff);
      if (mask[CSR_OSC_START])     write_reg(CSR_OSC_START, start);
      if (mask[CSR_ATTACK_LEN])    write_reg(CSR_ATTACK_LEN, 32'(attack));
      if (mask[CSR_DECAY_LEN])     write_reg(CSR_DECAY_LEN, 32'(decay));
      if (mask[CSR_SUSTAIN_LEN])   write_reg(CSR_SUSTAIN_LEN, 32'(sustain));
      if (mask[CSR_RELEASE_LEN])   write_reg(CSR_RELEASE_LEN, 32'(rel));
      if (mask[CSR_SUSTAIN_LEVEL]) write_reg(CSR_SUSTAIN_LEVEL, 32'(level));
      csr_wr_en <= 1'b0;
   endtask

   // Mostly short phases so that whole envelopes fit into a segment
   function automatic logic [23:0] pick_len();
      case ($urandom_range(0, 15))
         0:       return 24'd0;
         1:       return LEN_MAX;
         2:       return 24'($urandom_range(0, 24'hFF_FFFF));
         3:       return 24'($urandom_range(9, 300));
         default: return 24'($urandom_range(1, 8));
      endcase
   endfunction

   function automatic logic [16:0] pick_level();
      case ($urandom_range(0, 7))
         0:       return 17'd0;
         1:       return LEVEL_MAX;
         2:       return 17'($urandom_range(65537, 131071));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic logic [31:0] pick_coeff();
      case ($urandom_range(0, 7))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] pick_start();
      case ($urandom_range(0, 7))
         0:       return 32'hC000_0000;
         1:       return 32'h4000_0000;
         default: return 32'(longint'($urandom_range(0, 32'h8000_0000)) - 64'sd1073741824);
      endcase
   endfunction

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset values: one sustain tick at unity, then silent
      tick_series(1'b0, 2, 0);
      drain();

      // Single-tick phases, oscillator at its top extremes, level beyond unity
      load_envelope(7'h7F, 32'h7FFF_FFFF, 32'h4000_0000, 24'd1, 24'd1, 24'd1, 24'd1,
                    17'h1_FFFF);
      tick_series(1'b1, 5, 0);
      drain();

      // Every length zero: sustain error and silence, bottom extremes
      load_envelope(7'h7F, 32'h8000_0000, 32'hC000_0000, 24'd0, 24'd0, 24'd0, 24'd0,
                    17'd0);
      tick_series(1'b1, 3, 0);
      drain();

      // Longest phases: smallest ramp steps
      load_envelope(7'h7F, PI8_COEFF, PI8_START, LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX,
                    LEVEL_MAX);
      tick_series(1'b1, 3, 0);
      drain();

      // No attack: start in decay down to zero level, no release
      load_envelope(7'h7F, PI8_COEFF, PI8_START, 24'd0, 24'd2, 24'd1, 24'd0, 17'd0);
      tick_series(1'b1, 4, 0);
      drain();

      // No decay, and a restart in the middle of the envelope
      load_envelope(7'h7F, PI8_COEFF, PI8_START, 24'd2, 24'd0, 24'd2, 24'd2, LEVEL_MAX);
      tick_series(1'b1, 4, 0);
      tick_series(1'b1, 3, 0);

      // Random segments: mostly a restart then whole envelopes with the odd
      // restart, sometimes carrying on from where the last segment stopped
      while (items_sent < ITEM_TARGET) begin
         drain();
         load_envelope(7'($urandom_range(0, 127)), pick_coeff(), pick_start(), pick_len(),
                       pick_len(), pick_len(), pick_len(), pick_level());
         seg_len = $urandom_range(20, 90);
         tick_series($urandom_range(0, 5) != 0, seg_len, 25);
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/adsr_pkg.sv
rtl/adsr_div.sv
rtl/adsr_dp.sv
rtl/adsr_ctrl.sv
rtl/adsr_sine_tone_generator.sv
tb/adsr_tone_checker.sv
tb/tb.sv
